/* hw/rtl/trle_pkg.sv */
package trle_pkg;

	// Pixel codings selected by the format register
	typedef enum logic [1:0] {
		FMT_GRAY8  = 2'd0,
		FMT_RGB15  = 2'd1,
		FMT_BGR24  = 2'd2,
		FMT_BGRA32 = 2'd3
	} fmt_t;

	// Where the decoder stands within a packet
	typedef enum logic [0:0] {
		PH_HEADER = 1'b0,
		PH_PIXEL  = 1'b1
	} phase_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	localparam logic [7:0] ALPHA_SOLID = 8'd255;
	localparam logic [6:0] COUNT_MASK  = 7'h7F;

	// 5-bit to 8-bit channel widening
	localparam logic [7:0] WIDEN5 [32] = '{
		8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
		8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
		8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
		8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
	};

endpackage

/* hw/rtl/trle_pixel_unpack.sv */
module trle_pixel_unpack (
	input  trle_pkg::fmt_t  fmt,
	input  logic [23:0]     pixel_bytes,
	input  logic [7:0]      data_byte,
	output trle_pkg::rgba_t pixel
);

	logic [15:0] packed15;

	assign packed15 = {data_byte, pixel_bytes[7:0]};

	// Map the gathered bytes plus the closing byte onto RGBA
	always_comb begin
		pixel.red   = '0;
		pixel.green = '0;
		pixel.blue  = '0;
		pixel.alpha = trle_pkg::ALPHA_SOLID;
		case (fmt)
			trle_pkg::FMT_GRAY8: begin
				pixel.red = data_byte;
			end
			trle_pkg::FMT_RGB15: begin
				pixel.blue  = trle_pkg::WIDEN5[packed15[4:0]];
				pixel.green = trle_pkg::WIDEN5[packed15[9:5]];
				pixel.red   = trle_pkg::WIDEN5[packed15[14:10]];
			end
			trle_pkg::FMT_BGR24: begin
				pixel.blue  = pixel_bytes[7:0];
				pixel.green = pixel_bytes[15:8];
				pixel.red   = data_byte;
			end
			trle_pkg::FMT_BGRA32: begin
				pixel.blue  = pixel_bytes[7:0];
				pixel.green = pixel_bytes[15:8];
				pixel.red   = pixel_bytes[23:16];
				pixel.alpha = data_byte;
			end
			default: begin
				pixel.alpha = trle_pkg::ALPHA_SOLID;
			end
		endcase
	end

endmodule

/* hw/rtl/tga_rle_truecolor_pixel_decoder_unit.sv */
// Run-length coded truecolor pixel decoder. Takes one byte of coded pixel data
// per beat and gives at most one RGBA pixel per byte, with its repeat count
// (1 for raw packets, the clipped run length for run packets). Sustained rate
// is one byte per clock while out_stall is low; each byte passes an input
// register and then a result register, from which its result is presented.
// The image pixel count (width times height, zero dimensions counted as one)
// is formed by a 16x16 multiplier at the first header byte of each image.
// A byte with final_byte set ends the image; an early end gives truncated,
// with an empty result (repeat_count 0) when no pixel was completed by that
// byte. Write configuration only while the decoder is idle.
module tga_rle_truecolor_pixel_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// coded byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	// pixel output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  chan_red,
	output logic [7:0]  chan_green,
	output logic [7:0]  chan_blue,
	output logic [7:0]  chan_alpha,
	output logic [7:0]  repeat_count,
	output logic        last_pixel,
	output logic        all_opaque,
	output logic        truncated
);

	// configuration registers
	trle_pkg::fmt_t fmt_q;
	logic [15:0]    width_q;
	logic [15:0]    height_q;

	// input stage
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           fin_s1;

	// decoder state
	trle_pkg::phase_t phase_q, phase_n;
	logic [7:0]     packet_left_q, packet_left_n;
	logic           run_q, run_n;
	logic [1:0]     bip_q, bip_n;
	logic [23:0]    pixel_bytes_q, pixel_bytes_n;
	logic [31:0]    pixels_left_q, pixels_left_n;
	logic           opaque_q, opaque_n;
	logic           done_q, done_n;

	// result
	logic           emit;
	trle_pkg::rgba_t res_pix;
	logic [7:0]     res_rep;
	logic           res_last;
	logic           res_trunc;
	logic           res_opaque;
	logic           out_valid_q;

	logic           adv;
	logic           accept;
	trle_pkg::rgba_t unpacked;
	logic [15:0]    dim_w;
	logic [15:0]    dim_h;
	logic [31:0]    image_pixels;
	logic [7:0]     rep;
	logic [31:0]    left_after;

	assign cfg_ready = 1'b1;

	// Register configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= trle_pkg::FMT_BGR24;
			width_q  <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (trle_pkg::reg_idx_t'(cfg_index))
				trle_pkg::REG_FORMAT: fmt_q    <= trle_pkg::fmt_t'(cfg_data[1:0]);
				trle_pkg::REG_WIDTH:  width_q  <= cfg_data;
				trle_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the input beat when the result register can take its outcome
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			fin_s1  <= final_byte;
		end
	end

	trle_pixel_unpack u_unpack (
		.fmt         (fmt_q),
		.pixel_bytes (pixel_bytes_q),
		.data_byte   (byte_s1),
		.pixel       (unpacked)
	);

	// Pixel count of a new image
	assign dim_w        = (width_q == '0) ? 16'd1 : width_q;
	assign dim_h        = (height_q == '0) ? 16'd1 : height_q;
	assign image_pixels = {16'd0, dim_w} * {16'd0, dim_h};

	// Clip a run to what the image still lacks
	always_comb begin
		if (!run_q) begin
			rep = 8'd1;
		end else if (pixels_left_q < {24'd0, packet_left_q}) begin
			rep = pixels_left_q[7:0];
		end else begin
			rep = packet_left_q;
		end
	end

	assign left_after = pixels_left_q - {24'd0, rep};

	// Next state and result for the byte in the input stage
	always_comb begin
		phase_n       = phase_q;
		packet_left_n = packet_left_q;
		run_n         = run_q;
		bip_n         = bip_q;
		pixel_bytes_n = pixel_bytes_q;
		pixels_left_n = pixels_left_q;
		opaque_n      = opaque_q;
		done_n        = done_q;
		emit          = 1'b0;
		res_pix       = '0;
		res_rep       = '0;
		res_last      = 1'b0;
		res_trunc     = 1'b0;
		res_opaque    = opaque_q;
		if (!done_q) begin
			if (phase_q == trle_pkg::PH_HEADER) begin
				if (pixels_left_q == '0) begin
					pixels_left_n = image_pixels;
				end
				packet_left_n = {1'b0, byte_s1[6:0] & trle_pkg::COUNT_MASK} + 8'd1;
				run_n         = byte_s1[7];
				phase_n       = trle_pkg::PH_PIXEL;
				bip_n         = '0;
				pixel_bytes_n = '0;
				if (fin_s1) begin
					emit      = 1'b1;
					res_trunc = 1'b1;
				end
			end else if (bip_q < fmt_q) begin
				// gather one more byte of the pixel
				case (bip_q)
					2'd0: pixel_bytes_n[7:0]   = pixel_bytes_q[7:0] | byte_s1;
					2'd1: pixel_bytes_n[15:8]  = pixel_bytes_q[15:8] | byte_s1;
					2'd2: pixel_bytes_n[23:16] = pixel_bytes_q[23:16] | byte_s1;
					default: pixel_bytes_n     = pixel_bytes_q;
				endcase
				bip_n = bip_q + 2'd1;
				if (fin_s1) begin
					emit      = 1'b1;
					res_trunc = 1'b1;
				end
			end else begin
				// pixel complete
				opaque_n      = opaque_q && (unpacked.alpha == trle_pkg::ALPHA_SOLID);
				res_opaque    = opaque_n;
				packet_left_n = run_q ? 8'd0 :
					((packet_left_q == '0) ? 8'd0 : packet_left_q - 8'd1);
				pixels_left_n = left_after;
				bip_n         = '0;
				pixel_bytes_n = '0;
				if (packet_left_n == '0) begin
					phase_n = trle_pkg::PH_HEADER;
				end
				res_last = (left_after == '0);
				if (res_last) begin
					done_n = 1'b1;
				end
				emit      = 1'b1;
				res_pix   = unpacked;
				res_rep   = rep;
				res_trunc = fin_s1 && !res_last;
			end
		end
		// a final byte always rearms for the next image
		if (fin_s1) begin
			phase_n       = trle_pkg::PH_HEADER;
			packet_left_n = '0;
			run_n         = 1'b0;
			bip_n         = '0;
			pixel_bytes_n = '0;
			pixels_left_n = '0;
			opaque_n      = 1'b1;
			done_n        = 1'b0;
		end
	end

	// Hold decoder state, advance on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= trle_pkg::PH_HEADER;
			packet_left_q <= '0;
			run_q         <= 1'b0;
			bip_q         <= '0;
			pixel_bytes_q <= '0;
			pixels_left_q <= '0;
			opaque_q      <= 1'b1;
			done_q        <= 1'b0;
		end else if (adv) begin
			phase_q       <= phase_n;
			packet_left_q <= packet_left_n;
			run_q         <= run_n;
			bip_q         <= bip_n;
			pixel_bytes_q <= pixel_bytes_n;
			pixels_left_q <= pixels_left_n;
			opaque_q      <= opaque_n;
			done_q        <= done_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The reported flag is the value before a final byte rearms it
	always_ff @(posedge clk) begin
		if (adv && emit) begin
			chan_red     <= res_pix.red;
			chan_green   <= res_pix.green;
			chan_blue    <= res_pix.blue;
			chan_alpha   <= res_pix.alpha;
			repeat_count <= res_rep;
			last_pixel   <= res_last;
			all_opaque   <= res_opaque;
			truncated    <= res_trunc;
		end
	end

	assign out_valid = out_valid_q;

endmodule
